// ----- hdl/imu_ctf_pkg.sv -----
// ============================================================================
// IMU complementary tilt filter: shared package
// Field widths, fixed-point constants, register indexes, the unit status
// type and the arctangent table used by the CORDIC unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package imu_ctf_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS    = 15;  // fraction bits of all angles and samples
    localparam int ANGLE_BITS   = 30;  // fraction bits of the CORDIC angle accumulator
    localparam int WEIGHT_FRAC  = 15;  // fraction bits of the Q.15 weights

    // Field widths
    localparam int ACC_W        = 19;  // accelerometer sample and smoothed value
    localparam int GYRO_W       = 27;  // gyro rate
    localparam int TILT_W       = 25;  // blended tilt angle
    localparam int ANG_W        = 24;  // accelerometer angle
    localparam int WEIGHT_W     = 16;  // weight registers
    localparam int SHIFT_W      = 4;   // low-pass shift register
    localparam int CFG_IDX_W    = 2;   // register index
    localparam int CFG_DATA_W   = 16;  // widest register

    // CORDIC datapath
    localparam int TABLE_LEN        = 24;
    localparam int TABLE_IDX_W      = 5;
    localparam int ATAN_W           = 36;
    localparam int VEC_W            = 22;  // X and Y, including CORDIC gain
    localparam int Z_W              = 40;  // angle accumulator
    localparam int DEF_CORDIC_STEPS = 16;

    // Serial multiplier: signed multiplicand by unsigned Q.15 weight
    localparam int MCAND_W   = 29;
    localparam int PROD_W    = MCAND_W + WEIGHT_W;
    localparam int QUOT_W    = PROD_W - WEIGHT_FRAC;
    localparam int MUL_CNT_W = 4;

    // Angle limits
    localparam logic signed [Z_W-1:0]    Z_HALF_TURN = 40'sd193273528320; // 180 deg, Q.30
    localparam logic signed [ANG_W-1:0]  ANG_LIM     = 24'sd5898240;      // 180 deg
    localparam logic signed [TILT_W-1:0] TILT_LIM    = 25'sd11796480;     // 360 deg

    // Register reset values
    localparam logic [SHIFT_W-1:0]  RST_LOWPASS_SHIFT = 4'd6;
    localparam logic [WEIGHT_W-1:0] RST_GYRO_STEP     = 16'd32;
    localparam logic [WEIGHT_W-1:0] RST_BLEND_KEEP    = 16'd32735;
    localparam logic [WEIGHT_W-1:0] RST_ACCEL_MIX     = 16'd32;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWPASS_SHIFT = 2'd0,
        CFG_GYRO_STEP     = 2'd1,
        CFG_BLEND_KEEP    = 2'd2,
        CFG_ACCEL_MIX     = 2'd3
    } t_cfg_idx;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // atan(2^-i) in degrees, Q.30
    function automatic logic [ATAN_W-1:0] f_atan_deg(input logic [TABLE_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 36'd48318382080;
            5'd1:    v = 36'd28524006506;
            5'd2:    v = 36'd15071301663;
            5'd3:    v = 36'd7650428051;
            5'd4:    v = 36'd3840059795;
            5'd5:    v = 36'd1921901881;
            5'd6:    v = 36'd961185452;
            5'd7:    v = 36'd480622056;
            5'd8:    v = 36'd240314695;
            5'd9:    v = 36'd120157806;
            5'd10:   v = 36'd60078960;
            5'd11:   v = 36'd30039487;
            5'd12:   v = 36'd15019745;
            5'd13:   v = 36'd7509872;
            5'd14:   v = 36'd3754936;
            5'd15:   v = 36'd1877468;
            5'd16:   v = 36'd938734;
            5'd17:   v = 36'd469367;
            5'd18:   v = 36'd234684;
            5'd19:   v = 36'd117342;
            5'd20:   v = 36'd58671;
            5'd21:   v = 36'd29335;
            5'd22:   v = 36'd14668;
            5'd23:   v = 36'd7334;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/imu_complementary_tilt_filter_top.sv -----
// ============================================================================
// IMU complementary tilt filter: top level
// Low-passes the accelerometer, finds its tilt angle by CORDIC and blends
// it with the integrated gyro rate through a shared serial multiplier.
// ============================================================================
//
//  Channel  | Direction | Handshake                  | Beat contents
//  ---------+-----------+----------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_accel_x, i_accel_y, i_gyro_z
//  out      | output    | o_out_valid / i_out_ready  | o_tilt_angle, o_accel_angle
//  cfg      | input     | i_cfg_we (no back-pressure)| i_cfg_index, i_cfg_data
//
//  One sample goes through three passes of the serial multiplier from acceptance
//  to a result beat in the output register when the output is free; the CORDIC
//  runs alongside the first pass.
//  Only one sample is in flight; o_in_ready is high while the sequencer idles,
//  including while a finished beat waits in the output register.
//  A stalled output holds the sequencer in its final state.
//  Synchronous reset clears filter state and restores register defaults.
//
`timescale 1ns / 1ps
`default_nettype none

module imu_complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS = imu_ctf_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // Sample channel
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_ready,
    input  wire logic signed [imu_ctf_pkg::ACC_W-1:0]      i_accel_x,
    input  wire logic signed [imu_ctf_pkg::ACC_W-1:0]      i_accel_y,
    input  wire logic signed [imu_ctf_pkg::GYRO_W-1:0]     i_gyro_z,
    // Result channel
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_ready,
    output logic signed      [imu_ctf_pkg::TILT_W-1:0]     o_tilt_angle,
    output logic signed      [imu_ctf_pkg::ANG_W-1:0]      o_accel_angle,
    // Register writes
    input  wire logic                                      i_cfg_we,
    input  wire logic        [imu_ctf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [imu_ctf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = imu_ctf_pkg::ACC_W;
    localparam int MW = imu_ctf_pkg::MCAND_W;
    localparam int QW = imu_ctf_pkg::QUOT_W;
    localparam int TW = imu_ctf_pkg::TILT_W;
    localparam logic signed [QW:0] TILT_LIM_W = (QW+1)'(imu_ctf_pkg::TILT_LIM);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_DELTA = 7'b0000100,
        S_KEEP  = 7'b0001000,
        S_MIXW  = 7'b0010000,
        S_MIX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // Registers
    t_state                                   r_state;
    logic [imu_ctf_pkg::SHIFT_W-1:0]          r_lp_shift;
    logic [imu_ctf_pkg::WEIGHT_W-1:0]         r_gyro_w;
    logic [imu_ctf_pkg::WEIGHT_W-1:0]         r_keep_w;
    logic [imu_ctf_pkg::WEIGHT_W-1:0]         r_mix_w;
    logic signed [AW-1:0]                     r_sx;
    logic signed [AW-1:0]                     r_sy;
    logic signed [TW-1:0]                     r_blend;
    logic signed [imu_ctf_pkg::GYRO_W-1:0]    r_gz;
    logic signed [QW-1:0]                     r_keep_q;
    logic signed [TW-1:0]                     r_tilt;
    logic                                     r_out_valid;
    logic signed [TW-1:0]                     r_out_tilt;
    logic signed [imu_ctf_pkg::ANG_W-1:0]     r_out_acc;

    // Next values and unit connections
    logic signed [AW:0]                       n_dx;
    logic signed [AW:0]                       n_dy;
    logic signed [AW:0]                       n_qx;
    logic signed [AW:0]                       n_qy;
    logic signed [AW-1:0]                     n_sx;
    logic signed [AW-1:0]                     n_sy;
    logic signed [QW-1:0]                     n_sum_w;
    logic signed [MW-1:0]                     n_sum;
    logic signed [QW:0]                       n_tilt_w;
    logic signed [TW-1:0]                     n_tilt;
    logic                                     n_mul_start;
    logic signed [MW-1:0]                     n_mcand;
    logic [imu_ctf_pkg::WEIGHT_W-1:0]         n_weight;
    logic                                     n_in_acc;
    logic                                     n_out_free;

    imu_ctf_pkg::t_unit_stat                  mul_stat;
    imu_ctf_pkg::t_unit_stat                  cor_stat;
    logic signed [QW-1:0]                     mul_quot;
    logic signed [imu_ctf_pkg::ANG_W-1:0]     cor_angle;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_in_acc   = i_in_valid && o_in_ready;
    assign n_out_free = !r_out_valid || i_out_ready;

    // Exponential average: s += (a - s) >>> k. The sum lies between the old
    // value and the sample, so it is taken back to the field width.
    always_comb begin
        n_dx = {i_accel_x[AW-1], i_accel_x} - {r_sx[AW-1], r_sx};
        n_dy = {i_accel_y[AW-1], i_accel_y} - {r_sy[AW-1], r_sy};
        n_qx = n_dx >>> r_lp_shift;
        n_qy = n_dy >>> r_lp_shift;
        n_sx = r_sx + n_qx[AW-1:0];
        n_sy = r_sy + n_qy[AW-1:0];
    end

    // Previous angle plus the gyro step; it fits the multiplicand width.
    always_comb begin
        n_sum_w = {{(QW-TW){r_blend[TW-1]}}, r_blend} + mul_quot;
        n_sum   = n_sum_w[MW-1:0];
    end

    // Blend the two products and limit to a full turn either way.
    always_comb begin
        n_tilt_w = {r_keep_q[QW-1], r_keep_q} + {mul_quot[QW-1], mul_quot};
        if (n_tilt_w > TILT_LIM_W) begin
            n_tilt = imu_ctf_pkg::TILT_LIM;
        end else if (n_tilt_w < -TILT_LIM_W) begin
            n_tilt = -imu_ctf_pkg::TILT_LIM;
        end else begin
            n_tilt = n_tilt_w[TW-1:0];
        end
    end

    // Multiplier operand selection for the three passes.
    always_comb begin
        n_mul_start = 1'b0;
        n_mcand     = {{(MW-imu_ctf_pkg::GYRO_W){r_gz[imu_ctf_pkg::GYRO_W-1]}}, r_gz};
        n_weight    = r_gyro_w;
        case (r_state)
            S_START: begin
                n_mul_start = 1'b1;
            end
            S_DELTA: begin
                n_mul_start = mul_stat.done;
                n_mcand     = n_sum;
                n_weight    = r_keep_w;
            end
            S_MIXW: begin
                n_mul_start = !cor_stat.busy;
                n_mcand     = {{(MW-imu_ctf_pkg::ANG_W){cor_angle[imu_ctf_pkg::ANG_W-1]}},
                               cor_angle};
                n_weight    = r_mix_w;
            end
            default: begin
                n_mul_start = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DELTA;
                end
                S_DELTA: begin
                    if (mul_stat.done) begin
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: begin
                    if (mul_stat.done) begin
                        r_state <= S_MIXW;
                    end
                end
                S_MIXW: begin
                    if (!cor_stat.busy) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (mul_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_shift <= imu_ctf_pkg::RST_LOWPASS_SHIFT;
            r_gyro_w   <= imu_ctf_pkg::RST_GYRO_STEP;
            r_keep_w   <= imu_ctf_pkg::RST_BLEND_KEEP;
            r_mix_w    <= imu_ctf_pkg::RST_ACCEL_MIX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                imu_ctf_pkg::CFG_LOWPASS_SHIFT: r_lp_shift <= i_cfg_data[imu_ctf_pkg::SHIFT_W-1:0];
                imu_ctf_pkg::CFG_GYRO_STEP:     r_gyro_w   <= i_cfg_data;
                imu_ctf_pkg::CFG_BLEND_KEEP:    r_keep_w   <= i_cfg_data;
                imu_ctf_pkg::CFG_ACCEL_MIX:     r_mix_w    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Filter state: smoothed accelerometer and blended angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx    <= '0;
            r_sy    <= '0;
            r_blend <= '0;
        end else begin
            if (n_in_acc) begin
                r_sx <= n_sx;
                r_sy <= n_sy;
            end
            if (r_state == S_OUT && n_out_free) begin
                r_blend <= r_tilt;
            end
        end
    end

    // Working registers of the sample in flight.
    always_ff @(posedge i_clk) begin
        if (n_in_acc) begin
            r_gz <= i_gyro_z;
        end
        if (r_state == S_KEEP && mul_stat.done) begin
            r_keep_q <= mul_quot;
        end
        if (r_state == S_MIX && mul_stat.done) begin
            r_tilt <= n_tilt;
        end
    end

    // Output register: a result beat waits here until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && n_out_free) begin
            r_out_tilt <= r_tilt;
            r_out_acc  <= cor_angle;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tilt_angle  = r_out_tilt;
    assign o_accel_angle = r_out_acc;

    // Units
    imu_ctf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_mul_start),
        .i_mcand  (n_mcand),
        .i_weight (n_weight),
        .o_stat   (mul_stat),
        .o_quot   (mul_quot)
    );

    imu_ctf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .o_stat  (cor_stat),
        .o_angle (cor_angle)
    );

    // A new pass never starts over one still running.
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // Both units are quiet whenever a sample is taken in.
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_acc |-> (!mul_stat.busy && !cor_stat.busy))
        else $error("sample accepted while a unit is busy");

    // The accelerometer angle is final before it enters the blend.
    a_cordic_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIXW && n_mul_start) |-> !cor_stat.busy)
        else $error("blend started before the angle was ready");

    // The stored tilt never leaves a full turn either way.
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blend <= imu_ctf_pkg::TILT_LIM) && (r_blend >= -imu_ctf_pkg::TILT_LIM))
        else $error("blended angle out of range");

endmodule

`default_nettype wire

// ----- hdl/imu_ctf_mul.sv -----
// ============================================================================
// IMU complementary tilt filter: serial weight multiplier
// Shift-and-add multiplier taking one weight bit per cycle. Returns the
// signed product floored by 2^15.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module imu_ctf_mul (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_start,
    input  wire logic signed [imu_ctf_pkg::MCAND_W-1:0]    i_mcand,
    input  wire logic        [imu_ctf_pkg::WEIGHT_W-1:0]   i_weight,
    output imu_ctf_pkg::t_unit_stat                        o_stat,
    output logic signed      [imu_ctf_pkg::QUOT_W-1:0]     o_quot
);

    localparam int PW = imu_ctf_pkg::PROD_W;
    localparam int MW = imu_ctf_pkg::MCAND_W;
    localparam logic [imu_ctf_pkg::MUL_CNT_W-1:0] MUL_LAST =
        imu_ctf_pkg::MUL_CNT_W'(imu_ctf_pkg::WEIGHT_W - 1);

    logic signed [PW-1:0]                         r_acc;
    logic signed [PW-1:0]                         r_mcand;
    logic        [imu_ctf_pkg::WEIGHT_W-1:0]      r_weight;
    logic        [imu_ctf_pkg::MUL_CNT_W-1:0]     r_cnt;
    logic                                         r_busy;
    logic                                         r_done;

    // Control: one pass of sixteen weight bits, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the weight shifts out LSB first while the multiplicand
    // shifts up, adding into the accumulator where the weight bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{(PW-MW){i_mcand[MW-1]}}, i_mcand};
            r_weight <= i_weight;
        end else if (r_busy) begin
            if (r_weight[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_weight <= {1'b0, r_weight[imu_ctf_pkg::WEIGHT_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_acc[PW-1:imu_ctf_pkg::WEIGHT_FRAC];

endmodule

`default_nettype wire

// ----- hdl/imu_ctf_cordic.sv -----
// ============================================================================
// IMU complementary tilt filter: vectoring CORDIC
// Finds atan2(-x, -y) in degrees from the smoothed accelerometer values,
// one micro-rotation per cycle, then rounds and limits to +-180 degrees.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module imu_ctf_cordic #(
    parameter int STEPS = imu_ctf_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [imu_ctf_pkg::ACC_W-1:0]   i_sx,
    input  wire logic signed [imu_ctf_pkg::ACC_W-1:0]   i_sy,
    output imu_ctf_pkg::t_unit_stat                     o_stat,
    output logic signed      [imu_ctf_pkg::ANG_W-1:0]   o_angle
);

    localparam int N_STEPS = (STEPS > imu_ctf_pkg::TABLE_LEN) ? imu_ctf_pkg::TABLE_LEN : STEPS;
    localparam int IDX_W   = $clog2(N_STEPS);
    localparam int VW      = imu_ctf_pkg::VEC_W;
    localparam int ZW      = imu_ctf_pkg::Z_W;
    localparam int AW      = imu_ctf_pkg::ACC_W;
    localparam int RSH     = imu_ctf_pkg::ANGLE_BITS - imu_ctf_pkg::FRAC_BITS;
    localparam logic [IDX_W-1:0]     STEP_LAST = IDX_W'(N_STEPS - 1);
    localparam logic signed [ZW-1:0] Z_ROUND   = 40'sd1 <<< (RSH - 1);
    localparam logic signed [ZW-1:0] Z_LIM     = ZW'(imu_ctf_pkg::ANG_LIM);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ITER  = 3'b010,
        C_ROUND = 3'b100
    } t_cor_state;

    t_cor_state              r_state;
    logic [IDX_W-1:0]        r_i;
    logic signed [VW-1:0]    r_x;
    logic signed [VW-1:0]    r_y;
    logic signed [ZW-1:0]    r_z;
    logic                    r_zero;
    logic                    r_done;
    logic signed [imu_ctf_pkg::ANG_W-1:0] r_angle;

    logic signed [VW-1:0]    n_x0;
    logic signed [VW-1:0]    n_y0;
    logic signed [VW-1:0]    n_xp;
    logic signed [VW-1:0]    n_yp;
    logic signed [ZW-1:0]    n_zp;
    logic signed [VW-1:0]    n_xs;
    logic signed [VW-1:0]    n_ys;
    logic signed [ZW-1:0]    n_t;
    logic signed [ZW-1:0]    n_zr;
    logic signed [ZW-1:0]    n_zc;

    // Start vector, folded into the right half-plane.
    always_comb begin
        n_x0 = -{{(VW-AW){i_sy[AW-1]}}, i_sy};
        n_y0 = -{{(VW-AW){i_sx[AW-1]}}, i_sx};
        if (n_x0[VW-1]) begin
            n_xp = -n_x0;
            n_yp = -n_y0;
            n_zp = n_y0[VW-1] ? -imu_ctf_pkg::Z_HALF_TURN : imu_ctf_pkg::Z_HALF_TURN;
        end else begin
            n_xp = n_x0;
            n_yp = n_y0;
            n_zp = '0;
        end
    end

    // One micro-rotation: shifted copies and the table angle.
    always_comb begin
        n_xs = r_x >>> r_i;
        n_ys = r_y >>> r_i;
        n_t  = $signed({{(ZW-imu_ctf_pkg::ATAN_W){1'b0}},
                        imu_ctf_pkg::f_atan_deg(imu_ctf_pkg::TABLE_IDX_W'(r_i))});
    end

    // Round to nearest, ties up, then limit to a half turn.
    always_comb begin
        n_zr = (r_z + Z_ROUND) >>> RSH;
        if (n_zr > Z_LIM) begin
            n_zc = Z_LIM;
        end else if (n_zr < -Z_LIM) begin
            n_zc = -Z_LIM;
        end else begin
            n_zc = n_zr;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_i     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_ITER;
                        r_i     <= '0;
                    end
                end
                C_ITER: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == STEP_LAST) begin
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_state <= C_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    // Vector and angle datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_x    <= n_xp;
            r_y    <= n_yp;
            r_z    <= n_zp;
            r_zero <= (i_sx == '0) && (i_sy == '0);
        end else if (r_state == C_ITER) begin
            if (!r_y[VW-1]) begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_t;
            end else begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_t;
            end
        end
        if (r_state == C_ROUND) begin
            // A zero vector has no direction; its angle reads as zero.
            r_angle <= r_zero ? '0 : n_zc[imu_ctf_pkg::ANG_W-1:0];
        end
    end

    assign o_stat.busy = (r_state != C_IDLE);
    assign o_stat.done = r_done;
    assign o_angle     = r_angle;

endmodule

`default_nettype wire
